// ===== rtl/radt_pkg.sv =====
// ----------------------------------------------------------------------------
// radt_pkg
// shared types and constants for the recent address table
// ----------------------------------------------------------------------------
package radt_pkg;

    localparam int ADDR_W      = 48;
    localparam int TIME_W      = 32;
    localparam int SLOT_W      = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] stamp;
    } radt_item_t;

    typedef struct packed {
        logic       valid;
        radt_item_t item;
    } radt_queue_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } radt_state_t;

endpackage

// ===== rtl/radt_ram.sv =====
// ----------------------------------------------------------------------------
// radt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module radt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 10
) (
    clk,
    we,
    waddr,
    wdata,
    raddr,
    rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             clk;
    input  logic             we;
    input  logic [AW-1:0]    waddr;
    input  logic [WIDTH-1:0] wdata;
    input  logic [AW-1:0]    raddr;
    output logic [WIDTH-1:0] rdata;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/radt_front.sv =====
// ----------------------------------------------------------------------------
// radt_front
// input side: accepts items and holds them in a short queue for the engine
// ----------------------------------------------------------------------------
module radt_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [radt_pkg::ADDR_W-1:0] station_address,
    input  logic [radt_pkg::TIME_W-1:0] now_time,
    output radt_pkg::radt_queue_t       q_head,
    input  logic                        q_pop
);
    import radt_pkg::*;

    radt_item_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   full;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign in_stall = full;
    assign push     = in_valid && !full;

    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].addr  <= station_address;
            slot_reg[wr_ptr_reg].stamp <= now_time;
        end
    end

    // pop only from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> count_reg != '0)
        else $error("pop from empty queue");

    // occupancy never passes the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    // a push with no pop grows the occupancy by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

// ===== rtl/radt_back.sv =====
// ----------------------------------------------------------------------------
// radt_back
// lookup engine: walks the table one entry per cycle, then writes back and
// loads the result register
// ----------------------------------------------------------------------------
module radt_back #(
    parameter int TABLE_ENTRIES = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  radt_pkg::radt_queue_t       q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        is_new,
    output logic [radt_pkg::SLOT_W-1:0] slot_index
);
    import radt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam int ENTRY_W = ADDR_W + TIME_W;

    radt_state_t              state_reg;
    radt_state_t              state_next;
    radt_item_t               cur_reg;
    radt_item_t               cur_next;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         idx_next;
    logic                     chk_vld_reg;
    logic                     chk_vld_next;
    logic [IDX_W-1:0]         chk_idx_reg;
    logic [IDX_W-1:0]         chk_idx_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [IDX_W-1:0]         hit_idx_next;
    logic                     have_empty_reg;
    logic                     have_empty_next;
    logic                     have_victim_reg;
    logic                     have_victim_next;
    logic [IDX_W-1:0]         victim_reg;
    logic [IDX_W-1:0]         victim_next;
    logic [TIME_W-1:0]        oldest_reg;
    logic [TIME_W-1:0]        oldest_next;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     is_new_reg;
    logic                     is_new_next;
    logic [SLOT_W-1:0]        slot_reg;
    logic [SLOT_W-1:0]        slot_next;

    logic                     ram_we;
    logic [ENTRY_W-1:0]       ram_rdata;
    radt_item_t               rd_item;
    logic                     rd_entry_valid;
    logic                     can_load;

    radt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (victim_reg),
        .wdata (cur_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_item        = ram_rdata;
    assign rd_entry_valid = valid_reg[chk_idx_reg];
    assign can_load       = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        idx_next         = idx_reg;
        chk_vld_next     = 1'b0;
        chk_idx_next     = idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        have_empty_next  = have_empty_reg;
        have_victim_next = have_victim_reg;
        victim_next      = victim_reg;
        oldest_next      = oldest_reg;
        valid_next       = valid_reg;
        out_valid_next   = out_valid_reg && out_stall;
        is_new_next      = is_new_reg;
        slot_next        = slot_reg;
        q_pop            = 1'b0;
        ram_we           = 1'b0;

        // compare the entry whose data came back this cycle
        if (chk_vld_reg)
        begin
            if (rd_entry_valid && rd_item.addr == cur_reg.addr && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = chk_idx_reg;
            end
            if (!rd_entry_valid)
            begin
                if (!have_empty_reg)
                begin
                    have_empty_next = 1'b1;
                    victim_next     = chk_idx_reg;
                end
            end
            else if (!have_empty_reg)
            begin
                if (!have_victim_reg || rd_item.stamp < oldest_reg)
                begin
                    have_victim_next = 1'b1;
                    oldest_next      = rd_item.stamp;
                    victim_next      = chk_idx_reg;
                end
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop            = 1'b1;
                    cur_next         = q_head.item;
                    idx_next         = '0;
                    hit_next         = 1'b0;
                    have_empty_next  = 1'b0;
                    have_victim_next = 1'b0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                chk_vld_next = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    is_new_next    = !hit_reg;
                    if (hit_reg)
                    begin
                        slot_next = SLOT_W'(hit_idx_reg);
                    end
                    else
                    begin
                        slot_next              = SLOT_W'(victim_reg);
                        ram_we                 = 1'b1;
                        valid_next[victim_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        idx_reg         <= idx_next;
        chk_idx_reg     <= chk_idx_next;
        hit_reg         <= hit_next;
        hit_idx_reg     <= hit_idx_next;
        have_empty_reg  <= have_empty_next;
        have_victim_reg <= have_victim_next;
        victim_reg      <= victim_next;
        oldest_reg      <= oldest_next;
        is_new_reg      <= is_new_next;
        slot_reg        <= slot_next;
    end

    assign out_valid  = out_valid_reg;
    assign is_new     = is_new_reg;
    assign slot_index = slot_reg;

    // table writes happen only at write-back of an unseen address
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_WRITE) && !hit_reg)
        else $error("table write outside write-back");

    // an empty-entry victim really is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && have_empty_reg) |-> !valid_reg[victim_reg])
        else $error("empty victim already valid");

    // a reported duplicate points at a valid entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && hit_reg) |-> valid_reg[hit_idx_reg])
        else $error("hit on invalid entry");

    // the walk stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> idx_reg <= LAST_IDX)
        else $error("scan index out of range");

endmodule

// ===== rtl/recent_address_dedup_table.sv =====
// ----------------------------------------------------------------------------
// recent_address_dedup_table
// recent station address table with oldest-entry replacement
// ----------------------------------------------------------------------------
// Each item carries a 48-bit station address and a 32-bit time. The address is
// checked against every valid entry of a TABLE_ENTRIES deep table; a match
// returns is_new = 0 and the matching slot, otherwise the address and time go
// into the first empty slot, or else the slot with the smallest time (lowest
// slot on ties), and is_new = 1 is returned. The table is empty after reset.
// Each item takes these steps in order: the engine takes it from the input
// queue, issues the reads from the table RAM one table entry per cycle, waits
// for the last read to come back, then writes back and loads the result
// register, waiting there while a held result is not yet taken. A two-item input
// queue takes new items while the engine works and the result register holds
// a finished result until it is taken.
// ----------------------------------------------------------------------------
module recent_address_dedup_table #(
    parameter int TABLE_ENTRIES = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [radt_pkg::ADDR_W-1:0] station_address,
    input  logic [radt_pkg::TIME_W-1:0] now_time,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        is_new,
    output logic [radt_pkg::SLOT_W-1:0] slot_index
);
    import radt_pkg::*;

    radt_queue_t q_head;
    logic        q_pop;

    radt_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .station_address (station_address),
        .now_time        (now_time),
        .q_head          (q_head),
        .q_pop           (q_pop)
    );

    radt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_new     (is_new),
        .slot_index (slot_index)
    );

endmodule
